// ===== src/bcmp_pkg.sv =====
package bcmp_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TOUT_W  = 15;
    localparam int POUT_W  = 17;
    localparam int CIDX_W  = 3;

    // Internal datapath widths
    localparam int DT_W    = RAW_W + 1;            // dT = D2 - C5*2^8
    localparam int PRD_W   = DT_W + COEF_W + 1;    // dT * Cx
    localparam int TEMP_W  = 20;                   // unclipped TEMP
    localparam int TERM_W  = 40;                   // OFF / SENS
    localparam int SQ_W    = 36;                   // squared temperature deltas
    localparam int SPLIT_W = 20;                   // low slice of SENS for D1*SENS
    localparam int HI_W    = TERM_W - SPLIT_W;
    localparam int PLO_W   = RAW_W + SPLIT_W;
    localparam int PHI_W   = RAW_W + 1 + HI_W;
    localparam int FULL_W  = 64;
    localparam int PRES_W  = 29;                   // unclipped P

    // Scaling shifts
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int C5_SHIFT   = 8;
    localparam int C2_SHIFT   = 16;
    localparam int C1_SHIFT   = 15;
    localparam int P_SHIFT_A  = 21;
    localparam int P_SHIFT_B  = 15;

    // Temperature breakpoints
    localparam int TEMP_REF  = 2000;
    localparam int TEMP_COLD = -1500;

    // Output limits
    localparam int TEMP_LOW  = -4000;
    localparam int TEMP_HIGH = 8500;
    localparam int PRES_LOW  = 1000;
    localparam int PRES_HIGH = 120000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SENS      = 3'd0,
        CFG_OFF       = 3'd1,
        CFG_SENS_TEMP = 3'd2,
        CFG_OFF_TEMP  = 3'd3,
        CFG_REF_TEMP  = 3'd4,
        CFG_TEMP_COEF = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] sens_temp;
        logic [COEF_W-1:0] off_temp;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_coef;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [TERM_W-1:0] off;
        logic signed [TERM_W-1:0] sens;
    } terms_t;

endpackage

// ===== src/baro_pressure_compensation_core.sv =====
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  ----------------------------------------------
// s_        in         s_valid / s_ready    raw pressure D1, raw temperature D2 (24 b each)
// m_        out        m_valid / m_ready    temperature (0.01 C), pressure (Pa), saturated
// cfg_      in         cfg_wr_en            calibration word C1..C6 at cfg_index
//
// One word enters per cycle while no finished word is held at the output; each word
// passes through the ten register stages of the multiply datapath (three dT products,
// two squares, the split D1*SENS product, shift and clip).
// Reset (aresetn low, synchronous) clears the stage valid bits and the
// calibration words; the pipeline is empty and ready on the first cycle after.
// A stall on m_ready freezes every stage at once: nothing is dropped or repeated,
// and s_ready falls only while the output word is held.
// Write calibration words only while the pipeline is empty.
module baro_pressure_compensation_core
    import bcmp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [RAW_W-1:0]         s_raw_pressure,
    input  logic [RAW_W-1:0]         s_raw_temperature,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TOUT_W-1:0] m_temperature_centideg,
    output logic [POUT_W-1:0]        m_pressure_pa,
    output logic                     m_saturated,
    // calibration write port
    input  logic                     cfg_wr_en,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]        cfg_wdata
);

    cal_t   cal;
    logic   adv;
    logic   fo_valid, so_valid;
    terms_t fo_terms, so_terms;

    // Advance the whole pipe unless a finished word is held at the output.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Hold the six calibration words.
    bcmp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cal       (cal)
    );

    // Stages 1-3: dT, dT products, first-order TEMP / OFF / SENS.
    bcmp_first_order u_first (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .cal             (cal),
        .in_valid        (s_valid),
        .raw_pressure    (s_raw_pressure),
        .raw_temperature (s_raw_temperature),
        .out_valid       (fo_valid),
        .out_terms       (fo_terms)
    );

    // Stages 4-6: low-temperature corrections of OFF and SENS (TEMP itself unchanged).
    bcmp_second_order u_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fo_valid),
        .in_terms  (fo_terms),
        .out_valid (so_valid),
        .out_terms (so_terms)
    );

    // Stages 7-10: P = ((D1*SENS >> 21) - OFF) >> 15, then clip both results.
    bcmp_pressure u_pres (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .adv                  (adv),
        .in_valid             (so_valid),
        .in_terms             (so_terms),
        .out_valid            (m_valid),
        .temperature_centideg (m_temperature_centideg),
        .pressure_pa          (m_pressure_pa),
        .saturated            (m_saturated)
    );

endmodule

// ===== src/bcmp_cfg_regs.sv =====
module bcmp_cfg_regs
    import bcmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0] cfg_wdata,
    output cal_t              cal
);

    cal_t cal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SENS:      cal_reg.sens      <= cfg_wdata;
                CFG_OFF:       cal_reg.off       <= cfg_wdata;
                CFG_SENS_TEMP: cal_reg.sens_temp <= cfg_wdata;
                CFG_OFF_TEMP:  cal_reg.off_temp  <= cfg_wdata;
                CFG_REF_TEMP:  cal_reg.ref_temp  <= cfg_wdata;
                CFG_TEMP_COEF: cal_reg.temp_coef <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cal = cal_reg;

endmodule

// ===== src/bcmp_first_order.sv =====
module bcmp_first_order
    import bcmp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  cal_t             cal,
    input  logic             in_valid,
    input  logic [RAW_W-1:0] raw_pressure,
    input  logic [RAW_W-1:0] raw_temperature,
    output logic             out_valid,
    output terms_t           out_terms
);

    // stage 1: dT
    logic                    vld1_reg;
    logic signed [DT_W-1:0]  dt_reg, dt_next;
    logic [RAW_W-1:0]        d1_s1_reg;
    // stage 2: the three dT products
    logic                    vld2_reg;
    logic signed [PRD_W-1:0] pt_reg, pt_next;
    logic signed [PRD_W-1:0] po_reg, po_next;
    logic signed [PRD_W-1:0] ps_reg, ps_next;
    logic [RAW_W-1:0]        d1_s2_reg;
    // stage 3: first-order TEMP, OFF, SENS
    logic                    vld3_reg;
    terms_t                  t3_reg, t3_next;

    always_comb begin
        dt_next = $signed({1'b0, raw_temperature})
                - $signed({1'b0, cal.ref_temp, {C5_SHIFT{1'b0}}});
        pt_next = PRD_W'(dt_reg) * PRD_W'($signed({1'b0, cal.temp_coef}));
        po_next = PRD_W'(dt_reg) * PRD_W'($signed({1'b0, cal.off_temp}));
        ps_next = PRD_W'(dt_reg) * PRD_W'($signed({1'b0, cal.sens_temp}));
        t3_next.d1   = d1_s2_reg;
        t3_next.temp = TEMP_W'(TEMP_REF) + TEMP_W'(pt_reg >>> TEMP_SHIFT);
        t3_next.off  = $signed(TERM_W'({cal.off, {C2_SHIFT{1'b0}}}))
                     + TERM_W'(po_reg >>> OFF_SHIFT);
        t3_next.sens = $signed(TERM_W'({cal.sens, {C1_SHIFT{1'b0}}}))
                     + TERM_W'(ps_reg >>> SENS_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dt_reg    <= dt_next;
            d1_s1_reg <= raw_pressure;
            pt_reg    <= pt_next;
            po_reg    <= po_next;
            ps_reg    <= ps_next;
            d1_s2_reg <= d1_s1_reg;
            t3_reg    <= t3_next;
        end
    end

    assign out_valid = vld3_reg;
    assign out_terms = t3_reg;

endmodule

// ===== src/bcmp_second_order.sv =====
module bcmp_second_order
    import bcmp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   in_valid,
    input  terms_t in_terms,
    output logic   out_valid,
    output terms_t out_terms
);

    logic signed [TEMP_W-1:0] dw, dc;
    logic signed [2*TEMP_W-1:0] sqw_full, sqc_full;
    logic [TERM_W-1:0] sq5, sqc_ext;

    // stage 4: squares of the distances below 20 C and -15 C
    logic              vld4_reg;
    terms_t            t4_reg;
    logic [SQ_W-1:0]   sqw_reg, sqw_next;
    logic [SQ_W-1:0]   sqc_reg, sqc_next;
    logic              warm_lo_reg, warm_lo_next;
    logic              cold_lo_reg, cold_lo_next;
    // stage 5: correction terms
    logic              vld5_reg;
    terms_t            t5_reg;
    logic [TERM_W-1:0] off2_reg, off2_next;
    logic [TERM_W-1:0] sens2_reg, sens2_next;
    // stage 6: corrected OFF and SENS
    logic              vld6_reg;
    terms_t            t6_reg, t6_next;

    always_comb begin
        dw           = in_terms.temp - TEMP_W'(TEMP_REF);
        dc           = in_terms.temp - TEMP_W'(TEMP_COLD);
        sqw_full     = (2*TEMP_W)'(dw) * (2*TEMP_W)'(dw);
        sqc_full     = (2*TEMP_W)'(dc) * (2*TEMP_W)'(dc);
        sqw_next     = SQ_W'(sqw_full);
        sqc_next     = SQ_W'(sqc_full);
        warm_lo_next = dw[TEMP_W-1];
        cold_lo_next = dc[TEMP_W-1];

        sq5     = TERM_W'(sqw_reg) + (TERM_W'(sqw_reg) << 2);
        sqc_ext = TERM_W'(sqc_reg);
        off2_next  = '0;
        sens2_next = '0;
        if (warm_lo_reg) begin
            off2_next  = sq5 >> 1;
            sens2_next = sq5 >> 2;
            if (cold_lo_reg) begin
                off2_next  = (sq5 >> 1) + ((sqc_ext << 3) - sqc_ext);
                sens2_next = (sq5 >> 2)
                           + (((sqc_ext << 3) + (sqc_ext << 1) + sqc_ext) >> 1);
            end
        end

        t6_next      = t5_reg;
        t6_next.off  = t5_reg.off - $signed(off2_reg);
        t6_next.sens = t5_reg.sens - $signed(sens2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else if (adv) begin
            vld4_reg <= in_valid;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t4_reg      <= in_terms;
            sqw_reg     <= sqw_next;
            sqc_reg     <= sqc_next;
            warm_lo_reg <= warm_lo_next;
            cold_lo_reg <= cold_lo_next;
            t5_reg      <= t4_reg;
            off2_reg    <= off2_next;
            sens2_reg   <= sens2_next;
            t6_reg      <= t6_next;
        end
    end

    assign out_valid = vld6_reg;
    assign out_terms = t6_reg;

endmodule

// ===== src/bcmp_pressure.sv =====
module bcmp_pressure
    import bcmp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  terms_t                   in_terms,
    output logic                     out_valid,
    output logic signed [TOUT_W-1:0] temperature_centideg,
    output logic [POUT_W-1:0]        pressure_pa,
    output logic                     saturated
);

    logic [SPLIT_W-1:0]       sens_lo;
    logic signed [HI_W-1:0]   sens_hi;
    logic signed [FULL_W-1:0] scaled;

    // stage 7: partial products of D1 * SENS
    logic                     vld7_reg;
    logic [PLO_W-1:0]         plo_reg, plo_next;
    logic signed [PHI_W-1:0]  phi_reg, phi_next;
    logic signed [TEMP_W-1:0] temp7_reg;
    logic signed [TERM_W-1:0] off7_reg;
    // stage 8: full product
    logic                     vld8_reg;
    logic signed [FULL_W-1:0] full_reg, full_next;
    logic signed [TEMP_W-1:0] temp8_reg;
    logic signed [TERM_W-1:0] off8_reg;
    // stage 9: unclipped P
    logic                     vld9_reg;
    logic signed [PRES_W-1:0] pres_reg, pres_next;
    logic signed [TEMP_W-1:0] temp9_reg;
    // stage 10: clipped outputs
    logic                     vld10_reg;
    logic signed [TOUT_W-1:0] tout_reg, tout_next;
    logic [POUT_W-1:0]        pout_reg, pout_next;
    logic                     sat_reg, sat_next;

    always_comb begin
        sens_lo  = in_terms.sens[SPLIT_W-1:0];
        sens_hi  = in_terms.sens[TERM_W-1:SPLIT_W];
        plo_next = PLO_W'(in_terms.d1) * PLO_W'(sens_lo);
        phi_next = PHI_W'($signed({1'b0, in_terms.d1})) * PHI_W'(sens_hi);

        full_next = $signed({phi_reg[FULL_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}})
                  + $signed({{(FULL_W-PLO_W){1'b0}}, plo_reg});

        scaled    = (full_reg >>> P_SHIFT_A) - FULL_W'(off8_reg);
        pres_next = PRES_W'(scaled >>> P_SHIFT_B);

        sat_next  = 1'b0;
        tout_next = TOUT_W'(temp9_reg);
        if (temp9_reg < TEMP_W'(TEMP_LOW)) begin
            tout_next = TOUT_W'(TEMP_LOW);
            sat_next  = 1'b1;
        end else if (temp9_reg > TEMP_W'(TEMP_HIGH)) begin
            tout_next = TOUT_W'(TEMP_HIGH);
            sat_next  = 1'b1;
        end
        pout_next = POUT_W'(pres_reg);
        if (pres_reg < PRES_W'(PRES_LOW)) begin
            pout_next = POUT_W'(PRES_LOW);
            sat_next  = 1'b1;
        end else if (pres_reg > PRES_W'(PRES_HIGH)) begin
            pout_next = POUT_W'(PRES_HIGH);
            sat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld7_reg  <= 1'b0;
            vld8_reg  <= 1'b0;
            vld9_reg  <= 1'b0;
            vld10_reg <= 1'b0;
        end else if (adv) begin
            vld7_reg  <= in_valid;
            vld8_reg  <= vld7_reg;
            vld9_reg  <= vld8_reg;
            vld10_reg <= vld9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            temp7_reg <= in_terms.temp;
            off7_reg  <= in_terms.off;
            full_reg  <= full_next;
            temp8_reg <= temp7_reg;
            off8_reg  <= off7_reg;
            pres_reg  <= pres_next;
            temp9_reg <= temp8_reg;
            tout_reg  <= tout_next;
            pout_reg  <= pout_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid            = vld10_reg;
    assign temperature_centideg = tout_reg;
    assign pressure_pa          = pout_reg;
    assign saturated            = sat_reg;

endmodule

// ===== src/bcmp_checker.sv =====
module bcmp_checker
    import bcmp_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [RAW_W-1:0]         s_raw_pressure,
    input logic [RAW_W-1:0]         s_raw_temperature,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [TOUT_W-1:0] m_temperature_centideg,
    input logic [POUT_W-1:0]        m_pressure_pa,
    input logic                     m_saturated,
    input logic                     cfg_wr_en,
    input logic [CIDX_W-1:0]        cfg_index,
    input logic [COEF_W-1:0]        cfg_wdata
);

    // Input side stalls only while a result word is held.
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not track the output stall");

    // A held result word keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature_centideg)
            && $stable(m_pressure_pa) && $stable(m_saturated))
        else $error("result word changed while stalled");

    // Results always lie within the clip window.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_temperature_centideg >= TOUT_W'(TEMP_LOW)
            && m_temperature_centideg <= TOUT_W'(TEMP_HIGH)
            && m_pressure_pa >= POUT_W'(PRES_LOW)
            && m_pressure_pa <= POUT_W'(PRES_HIGH))
        else $error("result outside clip window");

    // A result strictly inside both windows was not clipped.
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_temperature_centideg > TOUT_W'(TEMP_LOW)
            && m_temperature_centideg < TOUT_W'(TEMP_HIGH)
            && m_pressure_pa > POUT_W'(PRES_LOW)
            && m_pressure_pa < POUT_W'(PRES_HIGH) |-> !m_saturated)
        else $error("saturated set on an unclipped result");

endmodule

bind baro_pressure_compensation_core bcmp_checker u_bcmp_checker (.*);

// ===== test/compensation_checker.sv =====
module compensation_checker
    import bcmp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [RAW_W-1:0]         s_raw_pressure,
    input  logic [RAW_W-1:0]         s_raw_temperature,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [TOUT_W-1:0] m_temperature_centideg,
    input  logic [POUT_W-1:0]        m_pressure_pa,
    input  logic                     m_saturated,
    input  logic                     cfg_wr_en,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]        cfg_wdata,
    output int                       mismatches,
    output int                       in_flight
);

    typedef struct {
        logic signed [TOUT_W-1:0] temp;
        logic [POUT_W-1:0]        pres;
        logic                     sat;
    } reading_t;

    cal_t     cal;
    reading_t readings_due[$];

    // Second-order compensation of one raw pair, in 64-bit signed arithmetic.
    function automatic reading_t compensate(input cal_t c, input logic [RAW_W-1:0] d1,
                                            input logic [RAW_W-1:0] d2);
        longint   d1v, dt, temp, off, sens, dsq, csq, off2, sens2, pres;
        reading_t r;
        d1v  = longint'(d1);
        dt   = longint'(d2) - (longint'(c.ref_temp) <<< C5_SHIFT);
        temp = TEMP_REF + ((dt * longint'(c.temp_coef)) >>> TEMP_SHIFT);
        off  = (longint'(c.off) <<< C2_SHIFT) + ((dt * longint'(c.off_temp)) >>> OFF_SHIFT);
        sens = (longint'(c.sens) <<< C1_SHIFT) + ((dt * longint'(c.sens_temp)) >>> SENS_SHIFT);
        if (temp < TEMP_REF) begin
            dsq   = (temp - TEMP_REF) * (temp - TEMP_REF);
            off2  = (5 * dsq) >>> 1;
            sens2 = (5 * dsq) >>> 2;
            if (temp < TEMP_COLD) begin
                csq   = (temp - TEMP_COLD) * (temp - TEMP_COLD);
                off2  = off2 + 7 * csq;
                sens2 = sens2 + ((11 * csq) >>> 1);
            end
            off  = off - off2;
            sens = sens - sens2;
        end
        pres  = (((d1v * sens) >>> P_SHIFT_A) - off) >>> P_SHIFT_B;
        r.sat = 1'b0;
        if (temp < TEMP_LOW) begin
            temp  = TEMP_LOW;
            r.sat = 1'b1;
        end
        if (temp > TEMP_HIGH) begin
            temp  = TEMP_HIGH;
            r.sat = 1'b1;
        end
        if (pres < PRES_LOW) begin
            pres  = PRES_LOW;
            r.sat = 1'b1;
        end
        if (pres > PRES_HIGH) begin
            pres  = PRES_HIGH;
            r.sat = 1'b1;
        end
        r.temp = TOUT_W'(temp);
        r.pres = POUT_W'(pres);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        reading_t want;
        if (!aresetn) begin
            cal = '0;
            readings_due.delete();
            in_flight = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    $error("unexpected word: temperature_centideg %0d, pressure_pa %0d",
                           m_temperature_centideg, m_pressure_pa);
                    mismatches++;
                end else begin
                    want = readings_due.pop_front();
                    if (m_temperature_centideg !== want.temp) begin
                        $error("temperature_centideg: expected %0d, got %0d",
                               want.temp, m_temperature_centideg);
                        mismatches++;
                    end
                    if (m_pressure_pa !== want.pres) begin
                        $error("pressure_pa: expected %0d, got %0d", want.pres, m_pressure_pa);
                        mismatches++;
                    end
                    if (m_saturated !== want.sat) begin
                        $error("saturated: expected %0d, got %0d", want.sat, m_saturated);
                        mismatches++;
                    end
                end
            end
            // predict with the calibration in force before this edge
            if (s_valid && s_ready)
                readings_due.push_back(compensate(cal, s_raw_pressure, s_raw_temperature));
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SENS:      cal.sens      = cfg_wdata;
                    CFG_OFF:       cal.off       = cfg_wdata;
                    CFG_SENS_TEMP: cal.sens_temp = cfg_wdata;
                    CFG_OFF_TEMP:  cal.off_temp  = cfg_wdata;
                    CFG_REF_TEMP:  cal.ref_temp  = cfg_wdata;
                    CFG_TEMP_COEF: cal.temp_coef = cfg_wdata;
                    default: ;
                endcase
            end
            in_flight = readings_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import bcmp_pkg::*;

    // Unused register indexes: writes there must leave the calibration alone.
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Slowest legal run: ~1130 words with random idle gaps, plus drains.
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 20;          // pipeline is 10 deep
    localparam int IDLE_MAX    = 13;
    localparam logic [RAW_W-1:0] NOMINAL_D1 = 24'd9085466;  // ~1000 hPa, factory words

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_pressure;
    logic [RAW_W-1:0]         s_raw_temperature;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [TOUT_W-1:0] m_temperature_centideg;
    logic [POUT_W-1:0]        m_pressure_pa;
    logic                     m_saturated;
    logic                     cfg_wr_en;
    logic [CIDX_W-1:0]        cfg_index;
    logic [COEF_W-1:0]        cfg_wdata;

    int                       mismatches;
    int                       in_flight;
    int                       cycle_count;

    // Reference word C5 in force, used to center raw temperatures on dT = 0.
    logic [COEF_W-1:0]        ref_word;
    // Burst flags: while set, that side inserts no idle cycles.
    logic                     src_steady;
    logic                     sink_steady;
    int unsigned              src_words;
    int unsigned              sink_words;

    baro_pressure_compensation_core u_top (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_raw_pressure         (s_raw_pressure),
        .s_raw_temperature      (s_raw_temperature),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_temperature_centideg (m_temperature_centideg),
        .m_pressure_pa          (m_pressure_pa),
        .m_saturated            (m_saturated),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata)
    );

    compensation_checker u_check (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_raw_pressure         (s_raw_pressure),
        .s_raw_temperature      (s_raw_temperature),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_temperature_centideg (m_temperature_centideg),
        .m_pressure_pa          (m_pressure_pa),
        .m_saturated            (m_saturated),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .mismatches             (mismatches),
        .in_flight              (in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Present one word at a falling edge and hold it until accepted.
    // Called at a falling edge; returns at the falling edge after the handshake.
    task automatic send_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        int unsigned gap;
        if (src_words % 40 == 0)
            src_steady = ($urandom_range(0, 3) == 0);
        src_words++;
        gap = src_steady ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            // drop valid and scribble on the idle payload
            s_valid           <= 1'b0;
            s_raw_pressure    <= RAW_W'($urandom);
            s_raw_temperature <= RAW_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_raw_pressure    <= d1;
        s_raw_temperature <= d2;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Send D1 with D2 placed at a given dT from the current C5, clamped to 24 bits.
    task automatic send_near_ref(input logic [RAW_W-1:0] d1, input longint dt);
        longint d2;
        d2 = (longint'(ref_word) <<< C5_SHIFT) + dt;
        if (d2 < 0)
            d2 = 0;
        if (d2 > longint'(24'hFFFFFF))
            d2 = longint'(24'hFFFFFF);
        send_word(d1, d2[RAW_W-1:0]);
    endtask

    // Mostly plausible readings that sweep the warm, cool and cold branches;
    // the rest are raw noise over the full 24-bit range.
    task automatic run_random(input int unsigned count);
        logic [RAW_W-1:0] d1;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0)
                d1 = RAW_W'($urandom);
            else
                d1 = RAW_W'($urandom_range(3500000, 11000000));
            if ($urandom_range(0, 7) == 0)
                send_word(d1, RAW_W'($urandom));
            else
                send_near_ref(d1, longint'($urandom_range(0, 4600000)) - 2300000);
        end
    endtask

    task automatic write_cal(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] word);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(negedge aclk);
    endtask

    // Write all six calibration words, then poke the spare indexes.
    task automatic load_cal(input cal_t c);
        write_cal(CFG_SENS, c.sens);
        write_cal(CFG_OFF, c.off);
        write_cal(CFG_SENS_TEMP, c.sens_temp);
        write_cal(CFG_OFF_TEMP, c.off_temp);
        write_cal(CFG_REF_TEMP, c.ref_temp);
        write_cal(CFG_TEMP_COEF, c.temp_coef);
        write_cal(CFG_SPARE_LO, COEF_W'($urandom));
        write_cal(CFG_SPARE_HI, COEF_W'($urandom));
        cfg_wr_en <= 1'b0;
        ref_word = c.ref_temp;
    endtask

    // Hold off new words and wait for every expected word to come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (in_flight != 0) @(negedge aclk);
    endtask

    // Factory-like words with jitter; a third of the fields fully random.
    function automatic cal_t near_cal(input cal_t base);
        cal_t r;
        int   w;
        r = base;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                w = $urandom_range(0, 65535);
            end else begin
                w = int'(base[i*COEF_W +: COEF_W]) + int'($urandom_range(0, 8191)) - 4096;
                if (w < 0)
                    w = 0;
                if (w > 65535)
                    w = 65535;
            end
            r[i*COEF_W +: COEF_W] = w[COEF_W-1:0];
        end
        return r;
    endfunction

    // Result side: stall a random number of cycles before taking each word.
    initial begin : sink
        int unsigned hold;
        m_ready     = 1'b0;
        sink_steady = 1'b0;
        sink_words  = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (sink_words % 40 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
            sink_words++;
            hold = sink_steady ? 0 : $urandom_range(0, IDLE_MAX);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        cal_t factory;
        factory = '{sens: 16'd40127, off: 16'd36924, sens_temp: 16'd23317,
                    off_temp: 16'd23282, ref_temp: 16'd33464, temp_coef: 16'd28312};
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_raw_pressure    = '0;
        s_raw_temperature = '0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        ref_word          = '0;
        src_steady        = 1'b0;
        src_words         = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Calibration still at reset: everything zero.
        run_random(10);

        drain();
        load_cal(factory);

        // Raw extremes and alternating bit patterns.
        send_word(24'h000000, 24'h000000);
        send_word(24'hFFFFFF, 24'hFFFFFF);
        send_word(24'h000000, 24'hFFFFFF);
        send_word(24'hFFFFFF, 24'h000000);
        send_word(24'hAAAAAA, 24'h555555);
        send_word(24'h555555, 24'hAAAAAA);
        send_word(24'd9085466, 24'd8569150);
        // Temperature breakpoints: 20 C exactly and just below,
        // -15 C exactly and just below, both clip edges.
        send_near_ref(NOMINAL_D1, 0);
        send_near_ref(NOMINAL_D1, -1);
        send_near_ref(NOMINAL_D1, -1037020);
        send_near_ref(NOMINAL_D1, -1037021);
        send_near_ref(NOMINAL_D1, -1777749);
        send_near_ref(NOMINAL_D1, -1777750);
        send_near_ref(NOMINAL_D1, 1926191);
        send_near_ref(NOMINAL_D1, 1926192);
        // Pressure clipping at room temperature, both sides.
        send_near_ref(24'h000000, 0);
        send_near_ref(24'hFFFFFF, 0);

        run_random(250);

        drain();
        load_cal('1);
        run_random(170);

        drain();
        load_cal('0);
        run_random(170);

        repeat (3) begin
            drain();
            load_cal(near_cal(factory));
            run_random(170);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bcmp_pkg.sv
src/bcmp_cfg_regs.sv
src/bcmp_first_order.sv
src/bcmp_second_order.sv
src/bcmp_pressure.sv
src/baro_pressure_compensation_core.sv
src/bcmp_checker.sv
test/compensation_checker.sv
test/tb_top.sv
